/* rtl/mutual_best_match_ratio_filter_assert.svh */
// ----------------------------------------------------------------------------
// mutual best match ratio filter assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef MUTUAL_BEST_MATCH_RATIO_FILTER_ASSERT_SVH
`define MUTUAL_BEST_MATCH_RATIO_FILTER_ASSERT_SVH

// same-cycle implication, off during reset
`define MBMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbmr port check failed");

// next-cycle implication, off during reset
`define MBMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbmr port check failed");

// next-cycle implication that also covers reset itself
`define MBMR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mbmr reset check failed");

`endif

/* rtl/mbmr_pkg.sv */
// ----------------------------------------------------------------------------
// mbmr_pkg
// shared constants, table word layouts and controller types
// ----------------------------------------------------------------------------
`default_nettype none

package mbmr_pkg;

  localparam int NUM_FIXED  = 64;
  localparam int NUM_MOVING = 64;
  localparam int DIST_W     = 16;
  localparam int IDX_W      = 6;
  localparam int RATIO_W    = 9;
  localparam int FIX_AW     = $clog2(NUM_FIXED);
  localparam int MOV_AW     = $clog2(NUM_MOVING);
  localparam int PROD_W     = DIST_W + RATIO_W;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO    = 1'b1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = 16'hFFFF;
  localparam logic [RATIO_W-1:0] MAX_RATIO_RST    = 9'd204;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_EV_RDF,
    ST_EV_RDM,
    ST_EV_CHK,
    ST_FLUSH
  } state_t;

  // fixed-side table word
  typedef struct packed {
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] second;
    logic [MOV_AW-1:0] partner;
  } fix_word_t;

  // moving-side table word
  typedef struct packed {
    logic [DIST_W-1:0] best;
    logic [FIX_AW-1:0] partner;
  } mov_word_t;

  typedef struct packed {
    logic add_acc;
    logic ev_acc;
    logic add_wr;
    logic rd_fix;
    logic rd_mov;
    logic check;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* rtl/mbmr_ctrl.sv */
// ----------------------------------------------------------------------------
// mbmr_ctrl
// sequencer for add read-modify-write and the evaluate scan
// ----------------------------------------------------------------------------
`default_nettype none

module mbmr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                operation,
  input  wire mbmr_pkg::ctrl_sts_t sts,
  output mbmr_pkg::ctrl_cmd_t      cmd,
  output logic                     busy
);

  mbmr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      mbmr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation == mbmr_pkg::OP_ADD) begin
            cmd.add_acc = 1'b1;
            state_next  = mbmr_pkg::ST_ADD_WR;
          end else begin
            cmd.ev_acc = 1'b1;
            state_next = mbmr_pkg::ST_EV_RDF;
          end
        end
      end
      mbmr_pkg::ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = mbmr_pkg::ST_IDLE;
      end
      mbmr_pkg::ST_EV_RDF: begin
        cmd.rd_fix = 1'b1;
        state_next = mbmr_pkg::ST_EV_RDM;
      end
      mbmr_pkg::ST_EV_RDM: begin
        cmd.rd_mov = 1'b1;
        state_next = mbmr_pkg::ST_EV_CHK;
      end
      mbmr_pkg::ST_EV_CHK: begin
        cmd.check  = 1'b1;
        state_next = sts.scan_last ? mbmr_pkg::ST_FLUSH : mbmr_pkg::ST_EV_RDF;
      end
      mbmr_pkg::ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = mbmr_pkg::ST_IDLE;
      end
      default: begin
        state_next = mbmr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mbmr_datapath.sv */
// ----------------------------------------------------------------------------
// mbmr_datapath
// match tables, valid bits, ratio test and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module mbmr_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mbmr_pkg::ctrl_cmd_t                 cmd,
  output mbmr_pkg::ctrl_sts_t                      sts,
  input  wire logic [mbmr_pkg::IDX_W-1:0]          fixed_index,
  input  wire logic [mbmr_pkg::IDX_W-1:0]          moving_index,
  input  wire logic [mbmr_pkg::DIST_W-1:0]         response,
  input  wire logic                                cfg_write,
  input  wire logic [mbmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbmr_pkg::CFG_W-1:0]          cfg_data,
  output logic                                     strobe,
  output logic [mbmr_pkg::IDX_W-1:0]               match_fixed_index,
  output logic [mbmr_pkg::IDX_W-1:0]               match_moving_index,
  output logic [mbmr_pkg::DIST_W-1:0]              match_response,
  output logic                                     match_valid,
  output logic                                     last_match
);

  // tables
  mbmr_pkg::fix_word_t fix_mem [mbmr_pkg::NUM_FIXED];
  mbmr_pkg::mov_word_t mov_mem [mbmr_pkg::NUM_MOVING];
  mbmr_pkg::fix_word_t fixed_q;
  mbmr_pkg::mov_word_t moving_q;

  logic [mbmr_pkg::NUM_FIXED-1:0]  fixed_seen;
  logic [mbmr_pkg::NUM_FIXED-1:0]  second_seen;
  logic [mbmr_pkg::NUM_MOVING-1:0] moving_seen;

  logic [mbmr_pkg::DIST_W-1:0]  max_distance;
  logic [mbmr_pkg::RATIO_W-1:0] max_ratio;

  logic [mbmr_pkg::FIX_AW-1:0] fix_r;
  logic [mbmr_pkg::MOV_AW-1:0] mov_r;
  logic [mbmr_pkg::DIST_W-1:0] dist_r;
  logic                        in_range;

  logic [mbmr_pkg::FIX_AW-1:0] scan_idx;
  logic [mbmr_pkg::PROD_W-1:0] prod;

  logic                        have_pend;
  logic [mbmr_pkg::FIX_AW-1:0] pend_f;
  logic [mbmr_pkg::MOV_AW-1:0] pend_m;
  logic [mbmr_pkg::DIST_W-1:0] pend_d;

  logic [mbmr_pkg::FIX_AW-1:0] fix_addr;
  logic [mbmr_pkg::MOV_AW-1:0] mov_addr;

  mbmr_pkg::fix_word_t fix_wr;
  logic                fix_second_set;
  mbmr_pkg::mov_word_t mov_wr;
  logic                mov_upd;

  logic [mbmr_pkg::PROD_W-1:0] best_sh;
  logic                        accept;

  assign fix_addr = cmd.rd_fix ? scan_idx : mbmr_pkg::FIX_AW'(fixed_index);
  assign mov_addr = cmd.rd_mov ? fixed_q.partner : mbmr_pkg::MOV_AW'(moving_index);

  assign in_range = (32'(fix_r) < mbmr_pkg::NUM_FIXED) &&
                    (32'(mov_r) < mbmr_pkg::NUM_MOVING);

  assign sts.scan_last = (scan_idx == mbmr_pkg::FIX_AW'(mbmr_pkg::NUM_FIXED - 1));

  // add update of the fixed and moving entries
  always_comb begin
    fix_wr         = fixed_q;
    fix_second_set = 1'b0;
    if (!fixed_seen[fix_r]) begin
      fix_wr.best    = dist_r;
      fix_wr.partner = mov_r;
    end else if (dist_r < fixed_q.best) begin
      fix_wr.second  = fixed_q.best;
      fix_wr.best    = dist_r;
      fix_wr.partner = mov_r;
      fix_second_set = 1'b1;
    end else if (!second_seen[fix_r] || dist_r < fixed_q.second) begin
      fix_wr.second  = dist_r;
      fix_second_set = 1'b1;
    end
    mov_wr.best    = dist_r;
    mov_wr.partner = fix_r;
    mov_upd        = !moving_seen[mov_r] || dist_r < moving_q.best;
  end

  // mutual best, distance limit and ratio test
  always_comb begin
    best_sh = mbmr_pkg::PROD_W'({fixed_q.best, 8'h00});
    accept  = fixed_seen[scan_idx] &&
              (fixed_q.best < max_distance) &&
              (!second_seen[scan_idx] || best_sh < prod) &&
              moving_seen[fixed_q.partner] &&
              (moving_q.partner == scan_idx);
  end

  // table ports
  always_ff @(posedge clk) begin
    if (cmd.add_acc || cmd.rd_fix) begin
      fixed_q <= fix_mem[fix_addr];
    end
    if (cmd.add_wr && in_range) begin
      fix_mem[fix_r] <= fix_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_acc || cmd.rd_mov) begin
      moving_q <= mov_mem[mov_addr];
    end
    if (cmd.add_wr && in_range && mov_upd) begin
      mov_mem[mov_r] <= mov_wr;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      fixed_seen  <= '0;
      second_seen <= '0;
      moving_seen <= '0;
    end else if (cmd.add_wr && in_range) begin
      fixed_seen[fix_r] <= 1'b1;
      if (fix_second_set) begin
        second_seen[fix_r] <= 1'b1;
      end
      if (mov_upd) begin
        moving_seen[mov_r] <= 1'b1;
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= mbmr_pkg::MAX_DISTANCE_RST;
      max_ratio    <= mbmr_pkg::MAX_RATIO_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        mbmr_pkg::REG_MAX_DISTANCE: max_distance <= cfg_data[mbmr_pkg::DIST_W-1:0];
        mbmr_pkg::REG_MAX_RATIO:    max_ratio    <= cfg_data[mbmr_pkg::RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // latched add operands, scan index and ratio product
  always_ff @(posedge clk) begin
    if (cmd.add_acc) begin
      fix_r  <= mbmr_pkg::FIX_AW'(fixed_index);
      mov_r  <= mbmr_pkg::MOV_AW'(moving_index);
      dist_r <= response;
    end
    if (cmd.ev_acc) begin
      scan_idx <= '0;
    end else if (cmd.check) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.rd_mov) begin
      prod <= mbmr_pkg::PROD_W'(max_ratio) * mbmr_pkg::PROD_W'(fixed_q.second);
    end
  end

  // one match held back so the final one can carry last_match
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.ev_acc) begin
        have_pend <= 1'b0;
      end else if (cmd.check && accept) begin
        have_pend <= 1'b1;
        if (have_pend) begin
          strobe <= 1'b1;
        end
      end else if (cmd.flush) begin
        strobe    <= 1'b1;
        have_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && accept) begin
      pend_f <= scan_idx;
      pend_m <= fixed_q.partner;
      pend_d <= fixed_q.best;
      if (have_pend) begin
        match_fixed_index  <= mbmr_pkg::IDX_W'(pend_f);
        match_moving_index <= mbmr_pkg::IDX_W'(pend_m);
        match_response     <= pend_d;
        match_valid        <= 1'b1;
        last_match         <= 1'b0;
      end
    end else if (cmd.flush) begin
      last_match <= 1'b1;
      if (have_pend) begin
        match_fixed_index  <= mbmr_pkg::IDX_W'(pend_f);
        match_moving_index <= mbmr_pkg::IDX_W'(pend_m);
        match_response     <= pend_d;
        match_valid        <= 1'b1;
      end else begin
        match_fixed_index  <= '0;
        match_moving_index <= '0;
        match_response     <= '0;
        match_valid        <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/mutual_best_match_ratio_filter.sv */
// ----------------------------------------------------------------------------
// mutual_best_match_ratio_filter
// mutual nearest match filter with distance limit and best/second ratio test
// add: table read at the transfer, then read-modify-write; busy during the
//   write, no result
// evaluate: per fixed entry a fixed read, a moving read + ratio multiply and
//   a check, then a final flush; results stream out
// results are one-cycle strobes; the receiver cannot stall
// reset: sync active high, clears valid bits and loads register defaults;
//   table contents are left as they are, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module mutual_best_match_ratio_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // command side, transfer when start && !busy
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           operation,
  input  wire logic [mbmr_pkg::IDX_W-1:0]     fixed_index,
  input  wire logic [mbmr_pkg::IDX_W-1:0]     moving_index,
  input  wire logic [mbmr_pkg::DIST_W-1:0]    response,
  // configuration writes
  input  wire logic                           cfg_write,
  input  wire logic [mbmr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbmr_pkg::CFG_W-1:0]     cfg_data,
  // result side, one transfer per strobe cycle
  output logic                                strobe,
  output logic [mbmr_pkg::IDX_W-1:0]          match_fixed_index,
  output logic [mbmr_pkg::IDX_W-1:0]          match_moving_index,
  output logic [mbmr_pkg::DIST_W-1:0]         match_response,
  output logic                                match_valid,
  output logic                                last_match
);

  mbmr_pkg::ctrl_cmd_t cmd;
  mbmr_pkg::ctrl_sts_t sts;

  // sequencer: idle, add write, the three-step scan per fixed entry and the final flush
  mbmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // tables, valid bits, tests, and the held-back match that lets the
  // final result of an evaluate carry last_match
  mbmr_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .fixed_index        (fixed_index),
    .moving_index       (moving_index),
    .response           (response),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .strobe             (strobe),
    .match_fixed_index  (match_fixed_index),
    .match_moving_index (match_moving_index),
    .match_response     (match_response),
    .match_valid        (match_valid),
    .last_match         (last_match)
  );

endmodule

`default_nettype wire

/* rtl/mbmr_checker.sv */
// ----------------------------------------------------------------------------
// mbmr_checker
// port-level checks on the filter, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "mutual_best_match_ratio_filter_assert.svh"

module mbmr_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        strobe,
  input wire logic [mbmr_pkg::IDX_W-1:0]  match_fixed_index,
  input wire logic [mbmr_pkg::DIST_W-1:0] match_response,
  input wire logic                        match_valid,
  input wire logic                        last_match
);

  // an empty evaluate result is always the final one
  `MBMR_ASSERT_IMP(a_empty_is_last, strobe && !match_valid, last_match)

  // an empty result carries zero fields
  `MBMR_ASSERT_IMP(a_empty_zero, strobe && !match_valid, match_fixed_index == '0 && match_response == '0)

  // every accepted command leaves the block busy in the cycle after it is taken
  `MBMR_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // a result that is not the final one only shows up while the scan still runs
  `MBMR_ASSERT_IMP(a_midscan, strobe && !last_match, busy)

  // after reset the block is idle and silent
  `MBMR_ASSERT_RST(a_reset_idle, rst, !busy && !strobe)

endmodule

bind mutual_best_match_ratio_filter mbmr_checker u_mbmr_checker (.*);

`default_nettype wire
